FILE: hw/rtl/upq_pkg.sv
`default_nettype none

package upq_pkg;

	// Widths of the result fields
	localparam int unsigned KEY_BITS   = 32;
	localparam int unsigned TOTAL_BITS = 7;

	// Configuration port
	localparam int unsigned PADDR_BITS = 3;
	localparam int unsigned PDATA_BITS = 32;
	localparam logic        REG_SIGNED_COMPARE = 1'b0;

	// Operation codes carried in the mode field
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_PEEK   = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic                  found;
		logic                  rejected;
		logic [TOTAL_BITS-1:0] total;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/unordered_array_max_priority_queue.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        to block   in_valid / in_ready   mode, key
// out       from block out_valid / out_ready result_key, found, rejected, entry_total
// config    to block   APB psel/penable      paddr, pwdata -> prdata
//
// Insert, a mode-3 no-op and delete/peek on an empty store go from idle
// straight to done. Delete and peek read each stored key once through the
// single store read port, then pass a final compare state before done.
// Reset clears the count and signed_compare; store contents need no clearing.
// A result waits in the output register; the next item is taken meanwhile
// and holds in its final state until that register frees up.

module unordered_array_max_priority_queue
	import upq_pkg::*;
#(
	parameter int unsigned CAPACITY  = 64,
	parameter int unsigned KEY_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            mode,
	input  wire logic [KEY_BITS-1:0]   key,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [KEY_BITS-1:0]        result_key,
	output logic                       found,
	output logic                       rejected,
	output logic [TOTAL_BITS-1:0]      entry_total,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0]      prdata,
	output logic                       pready
);

	logic    signed_compare_q;
	logic    res_valid;
	logic    res_take;
	logic    out_valid_q;
	result_t res;
	result_t out_q;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIGNED_COMPARE) ?
		PDATA_BITS'(signed_compare_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_compare_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_SIGNED_COMPARE)) begin
			signed_compare_q <= pwdata[0];
		end
	end

	upq_core #(
		.CAPACITY (CAPACITY),
		.KEY_WIDTH(KEY_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.signed_compare(signed_compare_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.key           (key),
		.res_valid     (res_valid),
		.res_ready     (res_take),
		.res           (res)
	);

	// Output register: load when empty or when its transfer completes
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_key  = out_q.key;
	assign found       = out_q.found;
	assign rejected    = out_q.rejected;
	assign entry_total = out_q.total;

endmodule

`default_nettype wire

FILE: hw/rtl/upq_store.sv
`default_nettype none

module upq_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/upq_core.sv
`default_nettype none

module upq_core
	import upq_pkg::*;
#(
	parameter int unsigned CAPACITY  = 64,
	parameter int unsigned KEY_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                signed_compare,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          mode,
	input  wire logic [KEY_BITS-1:0] key,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output result_t                  res
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned KW = KEY_WIDTH;
	localparam logic [KW-1:0] KEY_TOP = KW'(1) << (KW - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_LAST = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            op_del_q;
	logic [AW-1:0]   issue_q;
	logic            rd_vld_s1;
	logic            rd_first_s1;
	logic [AW-1:0]   rd_idx_s1;
	logic [KW-1:0]   best_key_q;
	logic [AW-1:0]   best_idx_q;
	result_t         res_q;

	logic [KW-1:0]   key_in;
	logic [KW-1:0]   flip;
	logic [KW-1:0]   rd_data;
	logic            take_new;
	logic [KW-1:0]   cur_best_key;
	logic [AW-1:0]   cur_best_idx;
	logic [CW-1:0]   count_m1;
	logic [AW-1:0]   last_addr;
	logic            full;
	logic            in_fire;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [KW-1:0]   wdata;
	logic            re;

	assign key_in    = KW'(key);
	assign flip      = signed_compare ? KEY_TOP : '0;
	assign count_m1  = count_q - 1'b1;
	assign last_addr = count_m1[AW-1:0];
	assign full      = (count_q >= CW'(CAPACITY));
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// Compare the returning entry against the running maximum; first index wins ties
	assign take_new     = rd_vld_s1 && (rd_first_s1 || ((rd_data ^ flip) > (best_key_q ^ flip)));
	assign cur_best_key = take_new ? rd_data : best_key_q;
	assign cur_best_idx = take_new ? rd_idx_s1 : best_idx_q;

	// Drive the store: append on insert, fill the hole on delete, read while scanning
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = key_in;
		if (in_fire && (mode == MODE_INSERT) && !full) begin
			we = 1'b1;
		end else if ((state_q == ST_LAST) && op_del_q) begin
			we    = 1'b1;
			waddr = cur_best_idx;
			wdata = rd_data;
		end
	end

	assign re = (state_q == ST_SCAN);

	upq_store #(
		.DEPTH(CAPACITY),
		.WIDTH(KW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(issue_q),
		.rdata(rd_data)
	);

	// Sequence one operation at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			op_del_q <= 1'b0;
			issue_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (mode)
							MODE_INSERT: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_DONE;
							end
							MODE_DELETE, MODE_PEEK: begin
								op_del_q <= (mode == MODE_DELETE);
								issue_q  <= '0;
								state_q  <= (count_q == '0) ? ST_DONE : ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					issue_q <= issue_q + 1'b1;
					if (issue_q == last_addr) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (op_del_q) begin
						count_q <= count_m1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Track the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= re;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1   <= issue_q;
		rd_first_s1 <= (issue_q == '0);
		if (take_new) begin
			best_key_q <= rd_data;
			best_idx_q <= rd_idx_s1;
		end
	end

	// Build the result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q.key      <= '0;
			res_q.found    <= 1'b0;
			res_q.rejected <= (mode == MODE_INSERT) && full;
			if ((mode == MODE_INSERT) && !full) begin
				res_q.total <= TOTAL_BITS'(count_q + 1'b1);
			end else begin
				res_q.total <= TOTAL_BITS'(count_q);
			end
		end else if (state_q == ST_LAST) begin
			res_q.key      <= KEY_BITS'(cur_best_key);
			res_q.found    <= 1'b1;
			res_q.rejected <= 1'b0;
			res_q.total    <= op_del_q ? TOTAL_BITS'(count_m1) : TOTAL_BITS'(count_q);
		end
	end

	// Count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	// A scan only runs over a non-empty store
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q != '0))
		else $error("scan started on empty store");

	// The final compare always has read data
	a_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAST) |-> rd_vld_s1)
		else $error("final compare without read data");

	// A delete that finds a key removes exactly one entry
	a_delete_dec: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LAST) && op_del_q) |=> (count_q == $past(count_m1)))
		else $error("delete did not drop one entry");

endmodule

`default_nettype wire

FILE: tb/tb_unordered_array_max_priority_queue.sv
`timescale 1ns / 100ps

module tb_unordered_array_max_priority_queue;
	import upq_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [PADDR_BITS-1:0] ADDR_SIGNED_COMPARE = PADDR_BITS'(4 * REG_SIGNED_COMPARE);
	// first byte address past the register list; writes there must be dropped
	localparam logic [PADDR_BITS-1:0] ADDR_PAST_END = PADDR_BITS'(4 * (REG_SIGNED_COMPARE + 1));
	localparam logic [KEY_BITS-1:0] KEY_SIGN = {1'b1, {(KEY_BITS-1){1'b0}}};
	localparam int unsigned PHASE_ITEMS = 120;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            mode;
	logic [KEY_BITS-1:0]   key;
	logic                  out_valid;
	logic                  out_ready;
	logic [KEY_BITS-1:0]   result_key;
	logic                  found;
	logic                  rejected;
	logic [TOTAL_BITS-1:0] entry_total;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	// Shadow copy of the queue contents and the compare setting
	logic [KEY_BITS-1:0] shadow_keys [DEPTH];
	int unsigned         shadow_count;
	logic                shadow_signed;
	result_t             expected_results [$];
	int unsigned         err_count = 0;
	bit                  idle_on = 1'b0;
	int unsigned         rx_hold = 0;

	unordered_array_max_priority_queue #(
		.CAPACITY  (DEPTH),
		.KEY_WIDTH (KEY_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.key         (key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_key  (result_key),
		.found       (found),
		.rejected    (rejected),
		.entry_total (entry_total),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Flip the sign bit so a plain unsigned compare follows the selected order
	function automatic logic [KEY_BITS-1:0] sort_value(logic [KEY_BITS-1:0] k);
		return shadow_signed ? (k ^ KEY_SIGN) : k;
	endfunction

	// Apply one operation to the shadow store and return the result it gives
	function automatic result_t apply_queue_op(logic [1:0] op, logic [KEY_BITS-1:0] k);
		result_t     r;
		int unsigned top;
		r = '0;
		case (op)
			MODE_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					shadow_keys[shadow_count] = k;
					shadow_count++;
				end
			end
			MODE_DELETE, MODE_PEEK: begin
				if (shadow_count > 0) begin
					// first index wins on equal keys
					top = 0;
					for (int unsigned i = 1; i < shadow_count; i++)
						if (sort_value(shadow_keys[i]) > sort_value(shadow_keys[top]))
							top = i;
					r.key = shadow_keys[top];
					r.found = 1'b1;
					if (op == MODE_DELETE) begin
						shadow_keys[top] = shadow_keys[shadow_count - 1];
						shadow_count--;
					end
				end
			end
			default: ;
		endcase
		r.total = TOTAL_BITS'(shadow_count);
		return r;
	endfunction

	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return KEY_SIGN;
			3: return ~KEY_SIGN;
			4, 5: return KEY_BITS'($urandom_range(0, 7));
			6: return '1 - KEY_BITS'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_mode(int unsigned insert_pct);
		if ($urandom_range(0, 99) < insert_pct)
			return MODE_INSERT;
		if ($urandom_range(0, 24) == 0)
			return MODE_UNUSED;
		return ($urandom_range(0, 2) == 0) ? MODE_PEEK : MODE_DELETE;
	endfunction

	task automatic report_mismatch(input string what, input logic [KEY_BITS-1:0] got,
		input logic [KEY_BITS-1:0] want);
		err_count++;
		if (err_count <= 20)
			$display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
	endtask

	// Offer one item, hold it until the transfer, then maybe idle a burst
	task automatic send_op(input logic [1:0] op, input logic [KEY_BITS-1:0] k);
		in_valid <= 1'b1;
		mode <= op;
		key <= k;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(apply_queue_op(op, k));
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Hold the sender until every expected result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_BITS-1:0] addr, input logic [PDATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_SIGNED_COMPARE)
			shadow_signed = data[0];
		// leave the bus idle between this access and the next
		@(posedge clk);
	endtask

	task automatic empty_store();
		int unsigned n;
		n = shadow_count;
		repeat (n) send_op(MODE_DELETE, pick_key());
	endtask

	task automatic test_empty_and_noop();
		send_op(MODE_PEEK, '1);
		send_op(MODE_DELETE, '0);
		send_op(MODE_UNUSED, '1);
		send_op(MODE_INSERT, '0);
		send_op(MODE_UNUSED, 32'h1234_5678);
		send_op(MODE_PEEK, '0);
		send_op(MODE_DELETE, '0);
		wait_drained();
	endtask

	task automatic test_unsigned_order();
		send_op(MODE_INSERT, '1);
		send_op(MODE_INSERT, KEY_SIGN);
		send_op(MODE_INSERT, ~KEY_SIGN);
		send_op(MODE_INSERT, '1);
		send_op(MODE_INSERT, 32'd1);
		send_op(MODE_PEEK, '0);
		repeat (6) send_op(MODE_DELETE, '1);
		wait_drained();
	endtask

	task automatic test_signed_order();
		write_reg(ADDR_SIGNED_COMPARE, '1);
		// a write past the register list must not clear the setting
		write_reg(ADDR_PAST_END, '0);
		send_op(MODE_INSERT, KEY_SIGN);
		send_op(MODE_INSERT, '1);
		send_op(MODE_INSERT, '0);
		send_op(MODE_INSERT, ~KEY_SIGN);
		send_op(MODE_INSERT, ~KEY_SIGN);
		send_op(MODE_PEEK, '0);
		repeat (6) send_op(MODE_DELETE, '0);
		wait_drained();
		write_reg(ADDR_SIGNED_COMPARE, '0);
	endtask

	// Stall the receiver long enough that the block backs up into its input
	task automatic test_fill_and_reject();
		idle_on = 1'b1;
		empty_store();
		rx_hold = 400;
		repeat (DEPTH + 6) send_op(MODE_INSERT, pick_key());
		send_op(MODE_PEEK, pick_key());
		repeat (DEPTH + 1) send_op(MODE_DELETE, pick_key());
		wait_drained();
	endtask

	task automatic test_random_mix();
		int unsigned weights [8] = '{85, 15, 70, 30, 90, 50, 10, 60};
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			write_reg(ADDR_SIGNED_COMPARE, (p % 2 == 0) ? PDATA_BITS'($urandom) : PDATA_BITS'(p % 3));
			idle_on = (p != 3);
			repeat (PHASE_ITEMS) send_op(pick_mode(weights[p]), pick_key());
		end
		wait_drained();
	endtask

	task automatic test_quiet_tail();
		idle_on = 1'b0;
		write_reg(ADDR_SIGNED_COMPARE, '1);
		repeat (100) send_op(pick_mode(50), pick_key());
		in_valid <= 1'b0;
	endtask

	// Receiver: long hold-off on request, else random stall bursts
	initial begin
		int unsigned stall;
		stall = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold != 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (stall != 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(0, 18);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, key", result_key, '0);
			end else begin
				want = expected_results.pop_front();
				if (result_key !== want.key)
					report_mismatch("result_key", result_key, want.key);
				if (found !== want.found)
					report_mismatch("found", KEY_BITS'(found), KEY_BITS'(want.found));
				if (rejected !== want.rejected)
					report_mismatch("rejected", KEY_BITS'(rejected), KEY_BITS'(want.rejected));
				if (entry_total !== want.total)
					report_mismatch("entry_total", KEY_BITS'(entry_total), KEY_BITS'(want.total));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned waited;
		in_valid <= 1'b0;
		mode <= MODE_INSERT;
		key <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		shadow_count = 0;
		shadow_signed = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_noop();
		test_unsigned_order();
		test_signed_order();
		test_fill_and_reject();
		test_random_mix();
		test_quiet_tail();

		// Drain, then leave room for any stray result
		waited = 0;
		while (expected_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_results.size() != 0)
			report_mismatch("results never arrived, count", KEY_BITS'(expected_results.size()), '0);
		repeat (DEPTH + 8) @(posedge clk);

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/upq_pkg.sv
hw/rtl/upq_store.sv
hw/rtl/upq_core.sv
hw/rtl/unordered_array_max_priority_queue.sv
tb/tb_unordered_array_max_priority_queue.sv
